### rtl/obsbs_pkg.sv
// ----------------------------------------------------------------------------
// obsbs_pkg
// Shared types and codes for the obstacle back-off sequencer.
// ----------------------------------------------------------------------------
package obsbs_pkg;

    // Action codes
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_ENCODER = 3'd1;
    localparam logic [2:0] ACT_START   = 3'd2;
    localparam logic [2:0] ACT_WAIT    = 3'd3;
    localparam logic [2:0] ACT_STOP    = 3'd4;
    localparam logic [2:0] ACT_CLEAR   = 3'd5;
    localparam logic [2:0] ACT_SENSOR  = 3'd6;

    // Motor commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_REVERSE = 3'd1;
    localparam logic [2:0] CMD_FORWARD = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_RESUME  = 3'd4;

    // Identification modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_WAITING = 2'd1;
    localparam logic [1:0] MODE_RUNNING = 2'd2;

    // Sensor codes
    localparam logic [2:0] CODE_REAR = 3'd3;

    // Register map (word index) and reset values
    localparam logic [1:0]  REG_HOLD_TICKS = 2'd0;
    localparam logic [1:0]  REG_STEP_LIMIT = 2'd1;
    localparam logic [1:0]  REG_AVOID_DUTY = 2'd2;
    localparam logic [15:0] HOLD_TICKS_RST = 16'd500;
    localparam logic [7:0]  STEP_LIMIT_RST = 8'd50;
    localparam logic [6:0]  AVOID_DUTY_RST = 7'd40;
    localparam logic [6:0]  DUTY_MAX       = 7'd100;
    localparam logic [7:0]  STEP_SAT       = 8'd255;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] sensor_code;
    } obsbs_in_t;

    typedef struct packed {
        logic [2:0] motor_command;
        logic       duty_valid;
        logic [6:0] duty_percent;
        logic       led_toggle;
        logic [1:0] ident_mode;
        logic       avoiding;
    } obsbs_out_t;

    typedef struct packed {
        logic [15:0] hold_ticks;
        logic [7:0]  step_limit;
        logic [6:0]  avoid_duty;
    } obsbs_cfg_t;

endpackage

### rtl/obsbs_regs.sv
// ----------------------------------------------------------------------------
// obsbs_regs
// APB configuration registers: hold_ticks, step_limit, avoid_duty.
// ----------------------------------------------------------------------------
module obsbs_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output obsbs_pkg::obsbs_cfg_t cfg
);
    import obsbs_pkg::*;

    obsbs_cfg_t cfg_reg;
    obsbs_cfg_t cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_HOLD_TICKS: cfg_next.hold_ticks = pwdata[15:0];
                REG_STEP_LIMIT: cfg_next.step_limit = pwdata[7:0];
                REG_AVOID_DUTY: cfg_next.avoid_duty = pwdata[6:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_ticks <= HOLD_TICKS_RST;
            cfg_reg.step_limit <= STEP_LIMIT_RST;
            cfg_reg.avoid_duty <= AVOID_DUTY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HOLD_TICKS: prdata = {16'd0, cfg_reg.hold_ticks};
            REG_STEP_LIMIT: prdata = {24'd0, cfg_reg.step_limit};
            REG_AVOID_DUTY: prdata = {25'd0, cfg_reg.avoid_duty};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### rtl/obsbs_core.sv
// ----------------------------------------------------------------------------
// obsbs_core
// Sequencer state and the single-pass update for one request.
// ----------------------------------------------------------------------------
module obsbs_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  obsbs_pkg::obsbs_in_t   item,
    input  obsbs_pkg::obsbs_cfg_t  cfg,
    output obsbs_pkg::obsbs_out_t  result
);
    import obsbs_pkg::*;

    typedef enum logic [1:0] {
        PH_ANNOUNCE = 2'd0,
        PH_LATCH    = 2'd1,
        PH_ACT      = 2'd2,
        PH_SPARE    = 2'd3
    } phase_t;

    logic [1:0]  mode_reg,     mode_next;
    logic [15:0] hold_reg,     hold_next;
    phase_t      phase_reg,    phase_next;
    logic [2:0]  latched_reg,  latched_next;
    logic [2:0]  code_reg,     code_next;
    logic        avoid_reg,    avoid_next;
    logic [7:0]  steps_reg,    steps_next;

    logic [15:0] hold_dec;
    logic [7:0]  steps_inc;
    logic [2:0]  cmd;
    logic        dvalid;
    logic        led;
    logic [6:0]  duty_sat;

    assign hold_dec  = (hold_reg != 16'd0) ? hold_reg - 16'd1 : 16'd0;
    assign steps_inc = (steps_reg != STEP_SAT) ? steps_reg + 8'd1 : steps_reg;
    assign duty_sat  = (cfg.avoid_duty > DUTY_MAX) ? DUTY_MAX : cfg.avoid_duty;

    always_comb begin
        mode_next    = mode_reg;
        hold_next    = hold_reg;
        phase_next   = phase_reg;
        latched_next = latched_reg;
        code_next    = code_reg;
        avoid_next   = avoid_reg;
        steps_next   = steps_reg;
        cmd          = CMD_NONE;
        dvalid       = 1'b0;
        led          = 1'b0;

        case (item.action)
            ACT_TICK: begin
                if (mode_reg == MODE_RUNNING && !avoid_reg) begin
                    hold_next = hold_dec;
                    if (hold_dec == 16'd0) begin
                        case (phase_reg)
                            PH_ANNOUNCE: begin
                                mode_next  = MODE_WAITING;
                                phase_next = PH_LATCH;
                            end
                            PH_LATCH: begin
                                latched_next = code_reg;
                                phase_next   = PH_ACT;
                            end
                            default: begin
                                // unmatched codes park the sequencer here
                                if (latched_reg <= CODE_REAR) begin
                                    cmd        = (latched_reg == CODE_REAR) ? CMD_FORWARD
                                                                            : CMD_REVERSE;
                                    dvalid     = 1'b1;
                                    avoid_next = 1'b1;
                                    mode_next  = MODE_IDLE;
                                    hold_next  = cfg.hold_ticks;
                                    phase_next = PH_ANNOUNCE;
                                end
                            end
                        endcase
                    end
                end else if (mode_reg == MODE_IDLE && hold_reg != 16'd0 &&
                             hold_reg != cfg.hold_ticks) begin
                    // rearm the hold-off while idle
                    hold_next  = cfg.hold_ticks;
                    phase_next = PH_ANNOUNCE;
                end
            end
            ACT_ENCODER: begin
                if (avoid_reg) begin
                    led = 1'b1;
                    if (steps_inc > cfg.step_limit) begin
                        cmd        = CMD_STOP;
                        avoid_next = 1'b0;
                        steps_next = 8'd0;
                    end else begin
                        steps_next = steps_inc;
                    end
                end else begin
                    steps_next = 8'd0;
                end
            end
            ACT_START: mode_next = MODE_RUNNING;
            ACT_WAIT:  mode_next = MODE_WAITING;
            ACT_STOP: begin
                if (mode_reg != MODE_IDLE) begin
                    cmd       = CMD_RESUME;
                    mode_next = MODE_IDLE;
                end
            end
            ACT_CLEAR: begin
                avoid_next = 1'b0;
                steps_next = 8'd0;
            end
            ACT_SENSOR: code_next = item.sensor_code;
            default: ;
        endcase
    end

    always_comb begin
        result.motor_command = cmd;
        result.duty_valid    = dvalid;
        result.duty_percent  = dvalid ? duty_sat : 7'd0;
        result.led_toggle    = led;
        result.ident_mode    = mode_next;
        result.avoiding      = avoid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            hold_reg    <= HOLD_TICKS_RST;
            phase_reg   <= PH_ANNOUNCE;
            latched_reg <= 3'd0;
            code_reg    <= 3'd0;
            avoid_reg   <= 1'b0;
            steps_reg   <= 8'd0;
        end else if (step_en) begin
            mode_reg    <= mode_next;
            hold_reg    <= hold_next;
            phase_reg   <= phase_next;
            latched_reg <= latched_next;
            code_reg    <= code_next;
            avoid_reg   <= avoid_next;
            steps_reg   <= steps_next;
        end
    end

    // a stop is only ordered on leaving avoidance
    a_stop_ends_avoid: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && cmd == CMD_STOP) |=> !avoid_reg)
        else $error("stop ordered but avoidance still active");

    // a drive order enters avoidance and rearms the hold-off
    a_drive_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && dvalid) |=> (avoid_reg && mode_reg == MODE_IDLE &&
                                 phase_reg == PH_ANNOUNCE))
        else $error("drive order did not enter avoidance cleanly");

    // the step count is cleared whenever avoidance is not running
    a_steps_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && item.action == ACT_ENCODER && !avoid_reg) |=> steps_reg == 8'd0)
        else $error("step count kept outside avoidance");

endmodule

### rtl/obstacle_backoff_sequencer_unit.sv
// ----------------------------------------------------------------------------
// obstacle_backoff_sequencer_unit
// Obstacle back-off sequencer with APB configuration and valid/ready channels.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input register, passes through the
//   update, and its result is captured in the result register for m_payload.
// Throughput: one request per cycle while m_ready is high; one-pass update.
// Reset: synchronous on aresetn low; registers return to their defaults and
//   the sequencer to idle with the hold-off loaded at 500 ticks.
module obstacle_backoff_sequencer_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  obsbs_pkg::obsbs_in_t   s_payload,
    output logic                   m_valid,
    input  logic                   m_ready,
    output obsbs_pkg::obsbs_out_t  m_payload,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import obsbs_pkg::*;

    obsbs_cfg_t cfg;
    obsbs_in_t  in_reg;
    logic       in_valid_reg;
    obsbs_out_t out_reg;
    logic       out_valid_reg;
    obsbs_out_t result;
    logic       advance;

    // move the held request on when the result slot is free or being drained
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    obsbs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    obsbs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (in_valid_reg && advance),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_payload;
        end
        if (advance && in_valid_reg) begin
            out_reg <= result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.duty_valid ? m_payload.duty_percent <= DUTY_MAX
                                          : m_payload.duty_percent == 7'd0))
        else $error("duty out of range or set without duty_valid");

    a_duty_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.duty_valid) |-> (m_payload.avoiding &&
            (m_payload.motor_command == CMD_FORWARD ||
             m_payload.motor_command == CMD_REVERSE)))
        else $error("duty issued without a drive order");

    a_led_avoid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.led_toggle) |->
            (m_payload.avoiding || m_payload.motor_command == CMD_STOP))
        else $error("led toggle outside avoidance");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the obstacle back-off sequencer unit. Requests go in
// through the valid/ready input channel, and a scoreboard predicts one result
// per request and compares it against the result channel field by field. The
// registers are programmed over APB between phases, while the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import obsbs_pkg::*;

    localparam logic [2:0] ACT_NOP           = 3'd7;
    localparam logic [2:0] CODE_FRONT_CENTRE = 3'd0;
    localparam logic [2:0] CODE_FRONT_LEFT   = 3'd1;
    localparam logic [2:0] CODE_FRONT_RIGHT  = 3'd2;

    localparam int REQUEST_TARGET   = 1700;
    localparam int PHASE_REQUESTS   = 60;
    localparam int MAX_TICK_RUN     = 30;
    localparam int LONG_HOLD_CYCLES = 40;
    localparam int SETTLE_CYCLES    = 6;
    localparam int MAX_REPORTS      = 10;

    typedef enum logic [1:0] {PH_ANNOUNCE, PH_LATCH, PH_ACT} seq_phase_t;

    class backoff_scoreboard;
        logic [15:0] hold_ticks;
        logic [7:0]  step_limit;
        logic [6:0]  avoid_duty;
        logic [1:0]  mode;
        logic [15:0] hold_count;
        seq_phase_t  phase;
        logic [2:0]  latched_code;
        logic [2:0]  current_code;
        logic        avoid_flag;
        logic [7:0]  step_count;
        obsbs_out_t  expected_results[$];
        int          failures;

        function new();
            hold_ticks   = HOLD_TICKS_RST;
            step_limit   = STEP_LIMIT_RST;
            avoid_duty   = AVOID_DUTY_RST;
            mode         = MODE_IDLE;
            hold_count   = HOLD_TICKS_RST;
            phase        = PH_ANNOUNCE;
            latched_code = '0;
            current_code = '0;
            avoid_flag   = 1'b0;
            step_count   = '0;
            failures     = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_HOLD_TICKS: hold_ticks = value[15:0];
                REG_STEP_LIMIT: step_limit = value[7:0];
                REG_AVOID_DUTY: avoid_duty = value[6:0];
                default: ;
            endcase
        endfunction

        function obsbs_out_t step_sequencer(obsbs_in_t req);
            obsbs_out_t res;
            res = '0;
            case (req.action)
                ACT_TICK: begin
                    if (mode == MODE_RUNNING && !avoid_flag) begin
                        if (hold_count != 0) hold_count = hold_count - 1'b1;
                        if (hold_count == 0) begin
                            if (phase == PH_ANNOUNCE) begin
                                mode  = MODE_WAITING;
                                phase = PH_LATCH;
                            end else if (phase == PH_LATCH) begin
                                latched_code = current_code;
                                phase        = PH_ACT;
                            end else if (latched_code <= CODE_REAR) begin
                                // front codes back away, the rear code drives ahead
                                res.motor_command = (latched_code == CODE_REAR) ?
                                                    CMD_FORWARD : CMD_REVERSE;
                                res.duty_valid    = 1'b1;
                                res.duty_percent  = (avoid_duty > DUTY_MAX) ?
                                                    DUTY_MAX : avoid_duty;
                                avoid_flag = 1'b1;
                                mode       = MODE_IDLE;
                                hold_count = hold_ticks;
                                phase      = PH_ANNOUNCE;
                            end
                        end
                    end else if (mode == MODE_IDLE && hold_count != 0 &&
                                 hold_count != hold_ticks) begin
                        hold_count = hold_ticks;
                        phase      = PH_ANNOUNCE;
                    end
                end
                ACT_ENCODER: begin
                    if (avoid_flag) begin
                        if (step_count != STEP_SAT) step_count = step_count + 1'b1;
                        res.led_toggle = 1'b1;
                        if (step_count > step_limit) begin
                            res.motor_command = CMD_STOP;
                            avoid_flag        = 1'b0;
                            step_count        = '0;
                        end
                    end else begin
                        step_count = '0;
                    end
                end
                ACT_START: mode = MODE_RUNNING;
                ACT_WAIT:  mode = MODE_WAITING;
                ACT_STOP: begin
                    if (mode != MODE_IDLE) begin
                        res.motor_command = CMD_RESUME;
                        mode              = MODE_IDLE;
                    end
                end
                ACT_CLEAR: begin
                    avoid_flag = 1'b0;
                    step_count = '0;
                end
                ACT_SENSOR: current_code = req.sensor_code;
                default: ;
            endcase
            res.ident_mode = mode;
            res.avoiding   = avoid_flag;
            return res;
        endfunction

        function void note_request(obsbs_in_t req);
            expected_results.push_back(step_sequencer(req));
        endfunction

        function void check_result(obsbs_out_t got);
            obsbs_out_t want;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result with nothing pending: %p", got);
                return;
            end
            want = expected_results.pop_front();
            if (got.motor_command !== want.motor_command ||
                got.duty_valid    !== want.duty_valid    ||
                got.duty_percent  !== want.duty_percent  ||
                got.led_toggle    !== want.led_toggle    ||
                got.ident_mode    !== want.ident_mode    ||
                got.avoiding      !== want.avoiding) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("mismatch: expected cmd=%0d dv=%0d duty=%0d led=%0d mode=%0d av=%0d,",
                             want.motor_command, want.duty_valid, want.duty_percent,
                             want.led_toggle, want.ident_mode, want.avoiding,
                             " got cmd=%0d dv=%0d duty=%0d led=%0d mode=%0d av=%0d",
                             got.motor_command, got.duty_valid, got.duty_percent,
                             got.led_toggle, got.ident_mode, got.avoiding);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    obsbs_in_t   s_payload;
    logic        m_valid;
    logic        m_ready;
    obsbs_out_t  m_payload;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    backoff_scoreboard sb;
    int tx_max_gap;
    int rx_max_gap;
    int rx_long_hold;
    int requests_sent;
    int unsigned cur_hold;
    int unsigned cur_limit;

    obstacle_backoff_sequencer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 aclk = ~aclk;

    // Both channels sampled at the edge that completes the handshake
    always @(posedge aclk) begin
        if (s_valid && s_ready) sb.note_request(s_payload);
        if (m_valid && m_ready) sb.check_result(m_payload);
    end

    // Result side: random stalls, and a long hold-off when asked for
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = (rx_max_gap == 0) ? 0 : $urandom_range(0, rx_max_gap);
            if (rx_long_hold > 0) begin
                stall        = rx_long_hold;
                rx_long_hold = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic send_request(input logic [2:0] action, input logic [2:0] code);
        obsbs_in_t req;
        int gap;
        req.action      = action;
        req.sensor_code = code;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input int unsigned hold, input int unsigned limit,
                              input int unsigned duty);
        cfg_write(REG_HOLD_TICKS, hold);
        cfg_write(REG_STEP_LIMIT, limit);
        cfg_write(REG_AVOID_DUTY, duty);
        cur_hold  = hold;
        cur_limit = limit;
    endtask

    // Let every pending result come back, then settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Full back-off: rearm, load code, run hold-off, latch, act, count steps
    task automatic avoid_sequence(input logic [2:0] code);
        int ticks;
        int pulses;
        ticks  = ((cur_hold > MAX_TICK_RUN) ? MAX_TICK_RUN : cur_hold) + $urandom_range(0, 1);
        pulses = cur_limit + 1 + $urandom_range(0, 2);
        send_request(ACT_STOP, 3'($urandom_range(0, 7)));
        send_request(ACT_TICK, 3'($urandom_range(0, 7)));
        send_request(ACT_SENSOR, code);
        send_request(ACT_START, 3'($urandom_range(0, 7)));
        repeat (ticks) send_request(ACT_TICK, 3'($urandom_range(0, 7)));
        send_request(ACT_START, 3'($urandom_range(0, 7)));
        send_request(ACT_TICK, 3'($urandom_range(0, 7)));
        send_request(ACT_TICK, 3'($urandom_range(0, 7)));
        repeat (pulses) send_request(ACT_ENCODER, 3'($urandom_range(0, 7)));
    endtask

    task automatic noise(input int count, input bit allow_unmatched);
        logic [2:0] action;
        logic [2:0] code;
        repeat (count) begin
            action = 3'($urandom_range(0, 7));
            code   = 3'($urandom_range(0, 7));
            // keep latched codes matched until the closing phase
            if (action == ACT_SENSOR && !allow_unmatched) code = 3'($urandom_range(0, 3));
            send_request(action, code);
        end
    endtask

    initial begin : stimulus
        int p;
        int phase_start;
        int unsigned h;
        int unsigned l;
        int unsigned d;
        sb            = new();
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_payload     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_max_gap    = 4;
        rx_max_gap    = 4;
        rx_long_hold  = 0;
        requests_sent = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle corners, one forward back-off with clipped duty
        set_config(1, 1, 127);
        send_request(ACT_STOP, 3'b111);
        send_request(ACT_NOP, 3'b000);
        send_request(ACT_ENCODER, 3'b101);
        send_request(ACT_TICK, 3'b010);
        send_request(ACT_SENSOR, CODE_REAR);
        send_request(ACT_START, 3'b100);
        send_request(ACT_TICK, 3'b000);
        send_request(ACT_START, 3'b000);
        send_request(ACT_TICK, 3'b000);
        send_request(ACT_TICK, 3'b000);
        send_request(ACT_ENCODER, 3'b000);
        send_request(ACT_ENCODER, 3'b000);
        send_request(ACT_WAIT, 3'b011);
        send_request(ACT_STOP, 3'b000);
        send_request(ACT_CLEAR, 3'b110);
        send_request(ACT_SENSOR, CODE_FRONT_LEFT);
        send_request(ACT_TICK, 3'b000);
        send_request(ACT_SENSOR, CODE_FRONT_CENTRE);
        send_request(ACT_SENSOR, CODE_FRONT_RIGHT);

        for (p = 0; requests_sent < REQUEST_TARGET; p++) begin
            drain();
            case (p)
                0: begin h = 0;     l = 1;   d = 0;   end
                1: begin h = 2;     l = 254; d = 100; end
                2: begin h = 1;     l = 255; d = 127; end
                3: begin h = 65535; l = 3;   d = 1;   end
                default: begin
                    h = $urandom_range(0, 4);
                    l = $urandom_range(1, 8);
                    d = $urandom_range(0, 127);
                end
            endcase
            set_config(h, l, d);
            tx_max_gap = (p % 3 == 1) ? 0 : 4;
            rx_max_gap = (p % 4 == 2) ? 0 : 4;
            if (p % 6 == 1) rx_long_hold = LONG_HOLD_CYCLES;
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_REQUESTS) begin
                if ($urandom_range(0, 3) != 0) avoid_sequence(3'($urandom_range(0, 3)));
                else noise($urandom_range(1, 6), 1'b0);
            end
        end

        // Closing phase: an unmatched code parks the sequencer in the act phase
        drain();
        set_config(1, 2, 55);
        tx_max_gap = 4;
        rx_max_gap = 4;
        avoid_sequence(3'($urandom_range(4, 7)));
        noise(20, 1'b1);
        drain();

        if (sb.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
